@@ sv/first_fit_block_allocator_top_defines.svh @@
// Assertion macros shared by the first-fit block allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ffba_pkg.sv @@
// Types, sizes and codes of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int SLOTS    = 16;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int MEM_SIZE = 1024;
  localparam int SIZE_W   = 11;
  localparam int OWNER_W  = 10;
  localparam int MODE_W   = 2;
  localparam int SUM_W    = SIZE_W + IDX_W;
  localparam int USED_W   = 11;

  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0]  start;
    logic [SIZE_W-1:0]  size;
    logic               busy;
    logic [OWNER_W-1:0] owner;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '{start: '0, size: '0, busy: 1'b0, owner: '0};
  localparam slot_t SLOT_INIT  = '{start: '0, size: SIZE_W'(MEM_SIZE), busy: 1'b0,
                                   owner: '0};

endpackage
`default_nettype wire

@@ sv/ffba_if.sv @@
// Request and response channel interfaces of the block allocator.
`default_nettype none
interface ffba_req_if;
  logic                           valid;
  logic                           ready;
  logic [ffba_pkg::MODE_W-1:0]    mode;
  logic [ffba_pkg::OWNER_W-1:0]   owner_id;
  logic [ffba_pkg::SIZE_W-1:0]    amount;
  modport source (output valid, mode, owner_id, amount, input ready);
  modport sink   (input valid, mode, owner_id, amount, output ready);
endinterface

interface ffba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [ffba_pkg::USED_W-1:0]   used_total;
  modport source (output valid, status, used_total, input ready);
  modport sink   (input valid, status, used_total, output ready);
endinterface
`default_nettype wire

@@ sv/first_fit_block_allocator_top.sv @@
// First-fit block allocator: table memory, slot sequencer and result register.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    mode, owner_id, amount
//   rsp_o    out  valid/ready    status, used_total
//
// Each item takes one pass over the table; merge adds a write-back of the
// compacted tail, and the result is then loaded into the result register.
// The pass reads one slot a cycle through the registered read port. Reset is
// immediate: per-slot valid bits make unwritten slots read as the reset table.
// A new item is taken while the previous result waits; the finished item
// holds until the result register is free.
`include "first_fit_block_allocator_top_defines.svh"
`default_nettype none
module first_fit_block_allocator_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ffba_req_if.sink    req_i,
  ffba_rsp_if.source  rsp_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_MTAIL = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // table memory
  ffba_pkg::slot_t                mem [ffba_pkg::SLOTS];
  ffba_pkg::slot_t                rd_q;
  logic [ffba_pkg::SLOTS-1:0]     vld_q;
  logic                           rvld_q;
  logic                           rzero_q;

  logic                           we;
  logic [ffba_pkg::IDX_W-1:0]     wa;
  ffba_pkg::slot_t                wd;
  logic [ffba_pkg::IDX_W-1:0]     ra;
  ffba_pkg::slot_t                rd_slot;

  // sequencer
  logic [1:0]                     state_q, state_d;
  logic [ffba_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [ffba_pkg::CNT_W-1:0]     wptr_q, wptr_d;
  logic                           found_q, found_d;
  logic                           shift_q, shift_d;
  logic                           accv_q, accv_d;
  ffba_pkg::slot_t                carry_q, carry_d;
  logic [ffba_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic [ffba_pkg::MODE_W-1:0]    mode_q, mode_d;
  logic [ffba_pkg::OWNER_W-1:0]   owner_q, owner_d;
  logic [ffba_pkg::SIZE_W-1:0]    amount_q, amount_d;

  logic                           out_valid_q, out_valid_d;
  logic                           out_status_q, out_status_d;
  logic [ffba_pkg::USED_W-1:0]    out_used_q, out_used_d;

  logic [ffba_pkg::IDX_W-1:0]     p_idx;
  logic [ffba_pkg::SIZE_W-1:0]    rest;
  logic                           in_fire;
  logic                           d_open;
  logic                           acc_open;

  function automatic logic [ffba_pkg::SUM_W-1:0] add_busy(
    input logic [ffba_pkg::SUM_W-1:0] s, input ffba_pkg::slot_t e);
    add_busy = e.busy ? s + ffba_pkg::SUM_W'(e.size) : s;
  endfunction

  assign in_fire     = req_i.valid & req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.used_total = out_used_q;

  // unwritten slots read as the reset table
  assign rd_slot = rvld_q ? rd_q : (rzero_q ? ffba_pkg::SLOT_INIT : ffba_pkg::SLOT_EMPTY);

  assign ra       = cnt_q[ffba_pkg::IDX_W-1:0];
  assign p_idx    = ffba_pkg::IDX_W'(cnt_q - ffba_pkg::CNT_W'(1));
  assign rest     = rd_slot.size - amount_q;
  assign d_open   = !rd_slot.busy && (rd_slot.size != '0);
  assign acc_open = accv_q && !carry_q.busy && (carry_q.size != '0);

  // sequence the pass over the table
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    wptr_d       = wptr_q;
    found_d      = found_q;
    shift_d      = shift_q;
    accv_d       = accv_q;
    carry_d      = carry_q;
    sum_d        = sum_q;
    mode_d       = mode_q;
    owner_d      = owner_q;
    amount_d     = amount_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_used_d   = out_used_q;
    we           = 1'b0;
    wa           = p_idx;
    wd           = rd_slot;

    // drop the result once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mode_d   = req_i.mode;
          owner_d  = req_i.owner_id;
          amount_d = req_i.amount;
          cnt_d    = '0;
          wptr_d   = '0;
          found_d  = 1'b0;
          shift_d  = 1'b0;
          accv_d   = 1'b0;
          sum_d    = '0;
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q != '0) begin
          case (mode_q)
            ffba_pkg::MODE_ALLOC: begin
              if (!found_q && amount_q != '0 && !rd_slot.busy &&
                  rd_slot.size >= amount_q) begin
                // take this block, split off any remainder unless it is the last slot
                we      = 1'b1;
                wd      = '{start: rd_slot.start, size: amount_q, busy: 1'b1,
                            owner: owner_q};
                found_d = 1'b1;
                sum_d   = sum_q + ffba_pkg::SUM_W'(amount_q);
                if (rest != '0 && p_idx != ffba_pkg::IDX_W'(ffba_pkg::SLOTS - 1)) begin
                  shift_d = 1'b1;
                  carry_d = '{start: rd_slot.start + amount_q, size: rest,
                              busy: 1'b0, owner: '0};
                end
              end else if (shift_q) begin
                // advance the later slots by one
                we      = 1'b1;
                wd      = carry_q;
                sum_d   = add_busy(sum_q, carry_q);
                carry_d = rd_slot;
              end else begin
                sum_d = add_busy(sum_q, rd_slot);
              end
            end
            ffba_pkg::MODE_FREE: begin
              if (!found_q && rd_slot.busy && rd_slot.owner == owner_q) begin
                we      = 1'b1;
                wd      = '{start: rd_slot.start, size: rd_slot.size, busy: 1'b0,
                            owner: '0};
                found_d = 1'b1;
              end else begin
                sum_d = add_busy(sum_q, rd_slot);
              end
            end
            ffba_pkg::MODE_MERGE: begin
              if (acc_open && d_open) begin
                carry_d.size = carry_q.size + rd_slot.size;
              end else begin
                // write out the held slot, hold the new one
                if (accv_q) begin
                  we     = 1'b1;
                  wa     = wptr_q[ffba_pkg::IDX_W-1:0];
                  wd     = carry_q;
                  sum_d  = add_busy(sum_q, carry_q);
                  wptr_d = wptr_q + ffba_pkg::CNT_W'(1);
                end
                carry_d = rd_slot;
                accv_d  = 1'b1;
              end
            end
            default: begin
              sum_d = add_busy(sum_q, rd_slot);
            end
          endcase
        end
        if (cnt_q == ffba_pkg::CNT_W'(ffba_pkg::SLOTS)) begin
          state_d = (mode_q == ffba_pkg::MODE_MERGE) ? ST_MTAIL : ST_FIN;
        end else begin
          cnt_d = cnt_q + ffba_pkg::CNT_W'(1);
        end
      end
      ST_MTAIL: begin
        // flush the held slot, then clear the vacated tail
        if (accv_q) begin
          we     = 1'b1;
          wa     = wptr_q[ffba_pkg::IDX_W-1:0];
          wd     = carry_q;
          sum_d  = add_busy(sum_q, carry_q);
          accv_d = 1'b0;
          wptr_d = wptr_q + ffba_pkg::CNT_W'(1);
        end else if (wptr_q != ffba_pkg::CNT_W'(ffba_pkg::SLOTS)) begin
          we     = 1'b1;
          wa     = wptr_q[ffba_pkg::IDX_W-1:0];
          wd     = ffba_pkg::SLOT_EMPTY;
          wptr_d = wptr_q + ffba_pkg::CNT_W'(1);
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          case (mode_q)
            ffba_pkg::MODE_ALLOC: out_status_d = !found_q;
            ffba_pkg::MODE_FREE:  out_status_d = !found_q;
            ffba_pkg::MODE_MERGE: out_status_d = 1'b0;
            default:              out_status_d = 1'b1;
          endcase
          out_used_d = (sum_q > ffba_pkg::SUM_W'(ffba_pkg::USED_MAX)) ?
                       ffba_pkg::USED_MAX : sum_q[ffba_pkg::USED_W-1:0];
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // table memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // slot valid bits and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      rzero_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[wa] <= 1'b1;
      end
      rvld_q  <= vld_q[ra];
      rzero_q <= (ra == '0);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      wptr_q      <= '0;
      found_q     <= 1'b0;
      shift_q     <= 1'b0;
      accv_q      <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wptr_q      <= wptr_d;
      found_q     <= found_d;
      shift_q     <= shift_d;
      accv_q      <= accv_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    carry_q      <= carry_d;
    mode_q       <= mode_d;
    owner_q      <= owner_d;
    amount_q     <= amount_d;
    out_status_q <= out_status_d;
    out_used_q   <= out_used_d;
  end

  `FFBA_ASSERT_NOW(a_no_rw_clash, (state_q == ST_RUN) && we && (cnt_q != ffba_pkg::CNT_W'(ffba_pkg::SLOTS)), wa != ra, "table write hits the slot being read")
  `FFBA_ASSERT_NOW(a_merge_wptr, (state_q == ST_RUN) && (mode_q == ffba_pkg::MODE_MERGE), wptr_q <= cnt_q, "merge write pointer passed the read pointer")
  `FFBA_ASSERT_NEXT(a_start_pass, in_fire, (state_q == ST_RUN) && (cnt_q == '0), "accepted item did not start a pass")
  `FFBA_ASSERT_NOW(a_fin_hold, (state_q == ST_FIN) && out_valid_q && !rsp_o.ready, state_d == ST_FIN, "finished item overwrote a pending result")

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench of the first-fit block allocator: table of directed items, then random.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import ffba_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  amount;
    bit                 known;
    logic               status;
    logic [USED_W-1:0]  used_total;
  } step_row_t;

  typedef struct {
    logic              status;
    logic [USED_W-1:0] used_total;
  } grant_t;

  logic clk_i;
  logic rst_ni;

  ffba_req_if req_if ();
  ffba_rsp_if rsp_if ();

  first_fit_block_allocator_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Predictor state: copy of the block table.
  slot_t  mem_map[SLOTS];
  grant_t grant_q[$];
  int     fail_cnt;
  int     idle_cycles;
  bit     stim_done;
  bit     hold_off;

  function automatic void map_reset();
    for (int k = 0; k < SLOTS; k++) mem_map[k] = SLOT_EMPTY;
    mem_map[0] = SLOT_INIT;
  endfunction

  function automatic logic [USED_W-1:0] busy_total();
    int sum;
    sum = 0;
    for (int k = 0; k < SLOTS; k++) if (mem_map[k].busy) sum += mem_map[k].size;
    return (sum > int'(USED_MAX)) ? USED_MAX : USED_W'(sum);
  endfunction

  function automatic logic place_block(logic [OWNER_W-1:0] who, logic [SIZE_W-1:0] amt);
    logic [SIZE_W-1:0] rest;
    if (amt == 0) return 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      if (!mem_map[k].busy && mem_map[k].size >= amt) begin
        rest = mem_map[k].size - amt;
        mem_map[k].size  = amt;
        mem_map[k].busy  = 1'b1;
        mem_map[k].owner = who;
        if (rest > 0 && k + 1 < SLOTS) begin
          for (int j = SLOTS - 1; j > k + 1; j--) mem_map[j] = mem_map[j-1];
          mem_map[k+1] = '{start: mem_map[k].start + amt, size: rest, busy: 1'b0,
                           owner: '0};
        end
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic release_owner(logic [OWNER_W-1:0] who);
    for (int k = 0; k < SLOTS; k++) begin
      if (mem_map[k].busy && mem_map[k].owner == who) begin
        mem_map[k].busy  = 1'b0;
        mem_map[k].owner = '0;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void coalesce_free();
    for (int k = 0; k < SLOTS - 1; k++) begin
      if (mem_map[k].busy || mem_map[k].size == 0) continue;
      while (k + 1 < SLOTS && !mem_map[k+1].busy && mem_map[k+1].size > 0) begin
        mem_map[k].size += mem_map[k+1].size;
        for (int j = k + 1; j < SLOTS - 1; j++) mem_map[j] = mem_map[j+1];
        mem_map[SLOTS-1] = SLOT_EMPTY;
      end
    end
  endfunction

  function automatic grant_t predict_grant(logic [MODE_W-1:0] m, logic [OWNER_W-1:0] who,
                                           logic [SIZE_W-1:0] amt);
    grant_t g;
    case (m)
      MODE_ALLOC: begin
        g.status = place_block(who, amt);
      end
      MODE_FREE: begin
        g.status = release_owner(who);
      end
      MODE_MERGE: begin
        coalesce_free();
        g.status = 1'b0;
      end
      default: begin
        g.status = 1'b1;
      end
    endcase
    g.used_total = busy_total();
    return g;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Directed table: expected values typed only where obvious.
  localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;
  step_row_t dir_rows[] = '{
    '{MODE_FREE,  10'd5,    11'd0,    1, 1'b1, 11'd0},
    '{MODE_ALLOC, 10'd1,    11'd0,    1, 1'b1, 11'd0},
    '{MODE_ALLOC, 10'd1,    11'd1025, 1, 1'b1, 11'd0},
    '{MODE_ALLOC, 10'd1,    11'd2047, 1, 1'b1, 11'd0},
    '{MODE_BAD,   10'd1023, 11'd2047, 1, 1'b1, 11'd0},
    '{MODE_MERGE, 10'd0,    11'd0,    1, 1'b0, 11'd0},
    '{MODE_ALLOC, 10'd1023, 11'd1024, 1, 1'b0, 11'd1024},
    '{MODE_ALLOC, 10'd2,    11'd1,    1, 1'b1, 11'd1024},
    '{MODE_FREE,  10'd1023, 11'd0,    1, 1'b0, 11'd0},
    '{MODE_ALLOC, 10'd0,    11'd1,    0, 1'b0, 11'd0},
    '{MODE_ALLOC, 10'd3,    11'd100,  0, 1'b0, 11'd0},
    '{MODE_ALLOC, 10'd4,    11'd200,  0, 1'b0, 11'd0},
    '{MODE_FREE,  10'd0,    11'd0,    0, 1'b0, 11'd0},
    '{MODE_FREE,  10'd3,    11'd0,    0, 1'b0, 11'd0},
    '{MODE_MERGE, 10'd0,    11'd0,    0, 1'b0, 11'd0},
    '{MODE_ALLOC, 10'd7,    11'd50,   0, 1'b0, 11'd0},
    '{MODE_FREE,  10'd4,    11'd0,    0, 1'b0, 11'd0},
    '{MODE_MERGE, 10'd0,    11'd0,    0, 1'b0, 11'd0},
    '{MODE_FREE,  10'd7,    11'd0,    0, 1'b0, 11'd0},
    '{MODE_MERGE, 10'd0,    11'd0,    0, 1'b0, 11'd0}
  };

  task automatic send_item(logic [MODE_W-1:0] m, logic [OWNER_W-1:0] who,
                           logic [SIZE_W-1:0] amt);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // drop valid only for a real gap, else offer the next item at once
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.owner_id <= who;
    req_if.amount   <= amt;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Random request with a bias toward well-formed alloc/free traffic on few owners.
  task automatic send_random();
    int pick;
    logic [MODE_W-1:0]  m;
    logic [OWNER_W-1:0] who;
    logic [SIZE_W-1:0]  amt;
    pick = $urandom_range(0, 99);
    who  = ($urandom_range(0, 4) == 0) ? OWNER_W'($urandom) : OWNER_W'($urandom_range(0, 7));
    if (pick < 45) m = MODE_ALLOC;
    else if (pick < 80) m = MODE_FREE;
    else if (pick < 95) m = MODE_MERGE;
    else m = MODE_BAD;
    case ($urandom_range(0, 9))
      0:       amt = SIZE_W'($urandom);
      1:       amt = '0;
      2, 3:    amt = SIZE_W'($urandom_range(1, 1024));
      default: amt = SIZE_W'($urandom_range(1, 96));
    endcase
    send_item(m, who, amt);
  endtask

  // Stimulus.
  initial begin
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_ALLOC;
    req_if.owner_id = '0;
    req_if.amount   = '0;
    stim_done       = 1'b0;
    rst_ni          = 1'b0;
    map_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].mode, dir_rows[i].owner_id, dir_rows[i].amount);
    end
    for (int n = 0; n < 1400; n++) send_random();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    stim_done = 1'b1;
  end

  // Predict on every accepted request; check typed rows against the table too.
  int row_idx;
  initial row_idx = 0;
  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && req_if.valid && req_if.ready) begin
      g = predict_grant(req_if.mode, req_if.owner_id, req_if.amount);
      if (row_idx < dir_rows.size()) begin
        if (dir_rows[row_idx].known &&
            (g.status !== dir_rows[row_idx].status ||
             g.used_total !== dir_rows[row_idx].used_total)) begin
          $display("%0t: row %0d exp status %0d used %0d, act %0d %0d", $time, row_idx,
                   dir_rows[row_idx].status, dir_rows[row_idx].used_total, g.status,
                   g.used_total);
          fail_cnt++;
        end
      end
      row_idx++;
      grant_q.push_back(g);
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the block.
  initial begin
    rsp_if.ready = 1'b0;
    hold_off     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_off && row_idx > 200) begin
        hold_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if ($urandom_range(0, 29) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(5, 60)) @(posedge clk_i);
      end
      rsp_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected item status %0d used %0d", $time, rsp_if.status,
                 rsp_if.used_total);
        fail_cnt++;
      end else begin
        g = grant_q.pop_front();
        if (rsp_if.status !== g.status) begin
          $display("%0t: status exp %0d act %0d", $time, g.status, rsp_if.status);
          fail_cnt++;
        end
        if (rsp_if.used_total !== g.used_total) begin
          $display("%0t: used_total exp %0d act %0d", $time, g.used_total,
                   rsp_if.used_total);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Finish.
  initial begin
    fail_cnt    = 0;
    idle_cycles = 0;
    fork
      begin
        wait (stim_done && grant_q.size() == 0);
        repeat (50) @(posedge clk_i);
        if (grant_q.size() != 0) begin
          $display("%0t: %0d items still expected", $time, grant_q.size());
          fail_cnt++;
        end
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: timeout, %0d items expected", $time, grant_q.size());
        fail_cnt++;
      end
    join_any
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
